[src/hmm_vit_pkg.sv]
`default_nettype none
package hmm_vit_pkg;

   localparam int MAX_STATES  = 16;
   localparam int MAX_SYMBOLS = 16;
   localparam int MAX_LEN     = 64;

   localparam int STATE_W = $clog2(MAX_STATES);
   localparam int SYM_W   = $clog2(MAX_SYMBOLS);
   localparam int TIME_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = TIME_W + 1;
   localparam int REG_W   = 5;
   localparam int LP_W    = 24;

   localparam logic signed [LP_W-1:0] LP_MIN = {1'b1, {(LP_W-1){1'b0}}};
   localparam logic signed [LP_W-1:0] LP_MAX = {1'b0, {(LP_W-1){1'b1}}};

   localparam logic [1:0] CSR_NUM_STATES  = 2'd0;
   localparam logic [1:0] CSR_NUM_SYMBOLS = 2'd1;

   typedef enum logic [2:0] {
      KIND_START   = 3'd0,
      KIND_TRANS   = 3'd1,
      KIND_EMIT    = 3'd2,
      KIND_OBSERVE = 3'd3,
      KIND_END     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACS,
      ST_FIN,
      ST_SEARCH,
      ST_EMIT,
      ST_NEXT
   } fsm_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic [3:0]              row_state;
      logic [3:0]              column_index;
      logic signed [LP_W-1:0]  log_value;
      logic [3:0]              symbol;
   } req_type;

   typedef struct packed {
      logic [3:0]              best_state;
      logic [5:0]              time_index;
      logic signed [LP_W-1:0]  path_log_prob;
      logic                    last;
      logic                    truncated;
      logic                    empty_res;
   } rsp_type;

   // table write broadcast to every cell
   typedef struct packed {
      logic                    wr_start;
      logic                    wr_trans;
      logic                    wr_emis;
      logic [STATE_W-1:0]      row;
      logic [STATE_W-1:0]      col;
      logic signed [LP_W-1:0]  value;
   } cell_wr_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic                    load;
      logic                    shift;
      logic                    acs;
      logic                    first_p;
      logic                    finish;
      logic                    use_start;
      logic [STATE_W-1:0]      pred;
      logic [SYM_W-1:0]        sym;
      logic                    sym_ok;
   } cell_ctrl_type;

   typedef logic [MAX_STATES-1:0][STATE_W-1:0] surv_row_type;

   function automatic logic signed [LP_W-1:0] sat_add(input logic signed [LP_W-1:0] a,
                                                     input logic signed [LP_W-1:0] b);
      logic signed [LP_W:0] s;
      s = {a[LP_W-1], a} + {b[LP_W-1], b};
      if (s[LP_W] != s[LP_W-1]) begin
         sat_add = s[LP_W] ? LP_MIN : LP_MAX;
      end else begin
         sat_add = s[LP_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

[src/hmm_vit_cell.sv]
`default_nettype none
module hmm_vit_cell (
   input  wire                                  clock,
   input  wire [hmm_vit_pkg::STATE_W-1:0]        cell_id,
   input  wire                                  en,
   input  hmm_vit_pkg::cell_wr_type             wr,
   input  hmm_vit_pkg::cell_ctrl_type           ctrl,
   input  wire signed [hmm_vit_pkg::LP_W-1:0]   head_pm,
   input  wire signed [hmm_vit_pkg::LP_W-1:0]   nbr_in,
   output logic signed [hmm_vit_pkg::LP_W-1:0]  shift_out,
   output logic [hmm_vit_pkg::STATE_W-1:0]      arg_out
);
   import hmm_vit_pkg::*;

   // column of the transition table ending in this state, row of emissions
   logic signed [LP_W-1:0] trans_mem [MAX_STATES];
   logic signed [LP_W-1:0] emis_mem  [MAX_SYMBOLS];
   logic signed [LP_W-1:0] start_ff;
   logic signed [LP_W-1:0] pm_ff;
   logic signed [LP_W-1:0] shift_ff;
   logic signed [LP_W-1:0] best_ff;
   logic [STATE_W-1:0]     arg_ff;

   logic signed [LP_W-1:0] cand;
   logic signed [LP_W-1:0] em;
   logic signed [LP_W-1:0] base;

   assign cand = sat_add(head_pm, trans_mem[ctrl.pred]);
   assign em   = ctrl.sym_ok ? emis_mem[ctrl.sym] : LP_MIN;
   assign base = ctrl.use_start ? start_ff : best_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_start && wr.row == cell_id) begin
         start_ff <= wr.value;
      end
      if (wr.wr_trans && wr.col == cell_id) begin
         trans_mem[wr.row] <= wr.value;
      end
      if (wr.wr_emis && wr.row == cell_id) begin
         emis_mem[wr.col] <= wr.value;
      end
      if (ctrl.load) begin
         shift_ff <= pm_ff;
      end else if (ctrl.shift) begin
         shift_ff <= nbr_in;
      end
      if (ctrl.acs && (ctrl.first_p || cand > best_ff)) begin
         best_ff <= cand;
         arg_ff  <= ctrl.pred;
      end
      if (ctrl.finish && en) begin
         pm_ff <= sat_add(base, em);
      end
   end

   assign shift_out = shift_ff;
   assign arg_out   = arg_ff;

endmodule
`default_nettype wire

[src/hmm_viterbi_decoder.sv]
`default_nettype none
// Channel  Direction  Ports                         Word
// req      in         req_valid req_ready req_word  kind,row_state,column_index,log_value,symbol
// rsp      out        rsp_valid rsp_ready rsp_word  best_state,time_index,path_log_prob,...
// csr      in         csr_valid csr_ready           csr_index, csr_data (always ready)
//
// Table writes go to the cells in the accept cycle. An observe word runs one ACS
// pass per predecessor through the cell chain, then a finish step; the first
// observe of a sequence runs only the finish step. An end word runs the
// best-state search, then emits the result words, and waits while rsp stalls.
// Reset clears the sequence count, overflow flag and handshake state and sets
// both counts to their maximum; tables, metrics and survivors hold garbage
// until written.
module hmm_viterbi_decoder (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  hmm_vit_pkg::req_type    req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output hmm_vit_pkg::rsp_type    rsp_word,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [1:0]               csr_index,
   input  wire [4:0]               csr_data
);
   import hmm_vit_pkg::*;

   fsm_type state_ff, state_in;

   logic [REG_W-1:0]       num_states_ff, num_symbols_ff;
   logic [REG_W-1:0]       ns_eff, nsym_eff;
   logic [CNT_W-1:0]       count_ff;
   logic                   overflow_ff;
   logic [STATE_W-1:0]     p_ff;
   logic [SYM_W-1:0]       sym_ff;
   logic                   empty_ff;
   logic [TIME_W-1:0]      t_ff;
   logic [STATE_W-1:0]     x_ff;
   logic signed [LP_W-1:0] best_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   req_fire;
   logic                   p_last;
   logic                   rsp_free;
   logic                   mem_we;
   logic                   rsp_load;
   logic                   seq_clear;

   cell_wr_type            wr;
   cell_ctrl_type          ctrl;
   logic [MAX_STATES-1:0]  en_vec;
   logic signed [LP_W-1:0] shift_out [MAX_STATES];
   logic signed [LP_W-1:0] nbr_in    [MAX_STATES];
   surv_row_type           arg_row;

   // survivor store: one row of all states per time step
   surv_row_type           surv_mem [MAX_LEN];
   surv_row_type           rd_row_ff;

   // counts clamp to 1..max
   assign ns_eff   = (num_states_ff == '0) ? REG_W'(1) :
                     (num_states_ff > REG_W'(MAX_STATES)) ? REG_W'(MAX_STATES) : num_states_ff;
   assign nsym_eff = (num_symbols_ff == '0) ? REG_W'(1) :
                     (num_symbols_ff > REG_W'(MAX_SYMBOLS)) ? REG_W'(MAX_SYMBOLS) :
                     num_symbols_ff;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign p_last    = ({1'b0, p_ff} == REG_W'(ns_eff - REG_W'(1)));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff  <= REG_W'(MAX_STATES);
         num_symbols_ff <= REG_W'(MAX_SYMBOLS);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_STATES:  num_states_ff  <= csr_data;
            CSR_NUM_SYMBOLS: num_symbols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // table writes go straight to the cells in the accept cycle
   always_comb begin
      wr.wr_start = req_fire && req_word.kind == KIND_START;
      wr.wr_trans = req_fire && req_word.kind == KIND_TRANS;
      wr.wr_emis  = req_fire && req_word.kind == KIND_EMIT;
      wr.row      = req_word.row_state;
      wr.col      = req_word.column_index;
      wr.value    = req_word.log_value;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_word.kind == KIND_OBSERVE
                && count_ff < CNT_W'(MAX_LEN)) begin
               state_in = (count_ff == '0) ? ST_FIN : ST_ACS;
            end else if (req_fire && req_word.kind == KIND_END) begin
               state_in = (count_ff == '0) ? ST_EMIT : ST_SEARCH;
            end
         end
         ST_ACS:    if (p_last) state_in = ST_FIN;
         ST_FIN:    state_in = ST_IDLE;
         ST_SEARCH: if (p_last) state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = (empty_ff || t_ff == '0) ? ST_IDLE : ST_NEXT;
            end
         end
         ST_NEXT:   state_in = ST_EMIT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ctrl.load      = req_fire && (req_word.kind == KIND_OBSERVE
                                    || req_word.kind == KIND_END);
      ctrl.shift     = 1'b0;
      ctrl.acs       = 1'b0;
      ctrl.first_p   = (p_ff == '0);
      ctrl.finish    = 1'b0;
      ctrl.use_start = (count_ff == '0);
      ctrl.pred      = p_ff;
      ctrl.sym       = sym_ff;
      ctrl.sym_ok    = ({1'b0, sym_ff} < nsym_eff);
      mem_we         = 1'b0;
      rsp_load       = 1'b0;
      seq_clear      = 1'b0;
      case (state_ff)
         ST_ACS: begin
            ctrl.shift = 1'b1;
            ctrl.acs   = 1'b1;
         end
         ST_FIN: begin
            ctrl.finish = 1'b1;
            mem_we      = (count_ff != '0);
         end
         ST_SEARCH: ctrl.shift = 1'b1;
         ST_EMIT: begin
            rsp_load  = rsp_free;
            seq_clear = rsp_free && (empty_ff || t_ff == '0);
         end
         default: ;
      endcase
   end

   // chain of cells: metrics shift toward cell 0, whose value is the head
   for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
      if (i == MAX_STATES - 1) begin : g_end
         assign nbr_in[i] = '0;
      end else begin : g_mid
         assign nbr_in[i] = shift_out[i+1];
      end
      assign en_vec[i] = (REG_W'(i) < ns_eff);
      hmm_vit_cell u_cell (
         .clock     (clock),
         .cell_id   (STATE_W'(i)),
         .en        (en_vec[i]),
         .wr        (wr),
         .ctrl      (ctrl),
         .head_pm   (shift_out[0]),
         .nbr_in    (nbr_in[i]),
         .shift_out (shift_out[i]),
         .arg_out   (arg_row[i])
      );
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int i = 0; i < MAX_STATES; i++) begin
            if (en_vec[i]) begin
               surv_mem[count_ff[TIME_W-1:0]][i] <= arg_row[i];
            end
         end
      end
      rd_row_ff <= surv_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire && req_word.kind == KIND_OBSERVE && count_ff >= CNT_W'(MAX_LEN)) begin
            overflow_ff <= 1'b1;
         end
         if (state_ff == ST_FIN) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (seq_clear) begin
            count_ff    <= '0;
            overflow_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers of the sequencer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_ff     <= '0;
         sym_ff   <= req_word.symbol;
         empty_ff <= (count_ff == '0);
         t_ff     <= (count_ff == '0) ? '0 : TIME_W'(count_ff - CNT_W'(1));
         x_ff     <= '0;
         best_ff  <= '0;
      end
      if (state_ff == ST_ACS || state_ff == ST_SEARCH) begin
         p_ff <= p_ff + STATE_W'(1);
      end
      if (state_ff == ST_SEARCH && (p_ff == '0 || shift_out[0] > best_ff)) begin
         best_ff <= shift_out[0];
         x_ff    <= p_ff;
      end
      if (state_ff == ST_NEXT) begin
         x_ff <= rd_row_ff[x_ff];
         t_ff <= t_ff - TIME_W'(1);
      end
      if (rsp_load) begin
         rsp_ff.best_state    <= x_ff;
         rsp_ff.time_index    <= t_ff;
         rsp_ff.path_log_prob <= best_ff;
         rsp_ff.last          <= empty_ff || t_ff == '0;
         rsp_ff.truncated     <= overflow_ff;
         rsp_ff.empty_res     <= empty_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LEN))
      else $error("sequence count beyond maximum length");

   a_pred_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACS || state_ff == ST_SEARCH) |-> ({1'b0, p_ff} < ns_eff))
      else $error("predecessor index beyond state count");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      seq_clear |=> (count_ff == '0 && !overflow_ff))
      else $error("sequence not cleared after final word");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff && !rsp_ready) |-> 1'b0)
      else $error("result overwritten while held");

endmodule
`default_nettype wire
